// File: hdl/replay_and_rate_admission_assert.svh
// Assertion macros shared by the replay and rate admission block.
`ifndef REPLAY_AND_RATE_ADMISSION_ASSERT_SVH
`define REPLAY_AND_RATE_ADMISSION_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RAR_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/rar_pkg.sv
// Types and constants shared by the replay and rate admission block.
`timescale 1ns / 1ps

package rar_pkg;

   localparam int QID_W       = 64;
   localparam int TIME_W      = 64;
   localparam int LEVEL_W     = 8;
   localparam int WINDOW_W    = 32;
   localparam int RATE_W      = 8;
   localparam int SLOT_FLD_W  = 4;
   localparam int PROD_W      = TIME_W + RATE_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_REPLAY = 2'd1;
   localparam logic [1:0] VERDICT_RATE   = 2'd2;

   localparam logic KIND_ADMIT = 1'b0;
   localparam logic KIND_OPEN  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST  = 2'd2;

   typedef struct packed {
      logic                  kind;
      logic [SLOT_FLD_W-1:0] peer_slot;
      logic [QID_W-1:0]      query_id_high;
      logic [QID_W-1:0]      query_id_low;
      logic [TIME_W-1:0]     now_s;
      logic                  is_find;
   } req_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic [LEVEL_W-1:0] tokens_left;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic fill;
      logic diff;
      logic mul;
      logic apply;
   } bucket_ctl_type;

endpackage

// File: hdl/rar_ram.sv
// Generic single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps

module rar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rar_bucket.sv
// Token bucket arithmetic for one peer slot: refill, capping and token spend.
`timescale 1ns / 1ps

module rar_bucket (
   input  logic                          clock,
   input  rar_pkg::bucket_ctl_type       ctl,
   input  logic [rar_pkg::LEVEL_W-1:0]   row_level,
   input  logic [rar_pkg::TIME_W-1:0]    row_refill,
   input  logic [rar_pkg::TIME_W-1:0]    now,
   input  logic [rar_pkg::LEVEL_W-1:0]   burst,
   input  logic [rar_pkg::RATE_W-1:0]    rate,
   output logic [rar_pkg::LEVEL_W-1:0]   level,
   output logic [rar_pkg::TIME_W-1:0]    refill,
   output logic                          deny
);

   logic [rar_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [rar_pkg::TIME_W-1:0]   refill_ff, refill_in;
   logic [rar_pkg::TIME_W-1:0]   diff_ff, diff_in;
   logic                         gt_ff, gt_in;
   logic [rar_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                         deny_ff, deny_in;
   logic [rar_pkg::TIME_W-1:0]   eff_refill;
   logic [rar_pkg::PROD_W:0]     sum;
   logic [rar_pkg::LEVEL_W-1:0]  capped;

   assign eff_refill = (refill_ff == '0) ? now : refill_ff;
   assign sum = (rar_pkg::PROD_W + 1)'(level_ff) + (rar_pkg::PROD_W + 1)'(prod_ff);

   always_comb begin
      if (!gt_ff) begin
         capped = level_ff;
      end else if (sum > (rar_pkg::PROD_W + 1)'(burst)) begin
         capped = burst;
      end else begin
         capped = sum[rar_pkg::LEVEL_W-1:0];
      end
   end

   always_comb begin
      level_in  = level_ff;
      refill_in = refill_ff;
      diff_in   = diff_ff;
      gt_in     = gt_ff;
      prod_in   = prod_ff;
      deny_in   = deny_ff;
      if (ctl.load) begin
         level_in  = row_level;
         refill_in = row_refill;
         deny_in   = 1'b0;
      end else if (ctl.fill) begin
         level_in  = burst;
         refill_in = now;
         deny_in   = 1'b0;
      end else if (ctl.diff) begin
         if (refill_ff == '0) begin
            level_in = burst;
         end
         refill_in = eff_refill;
         diff_in   = now - eff_refill;
         gt_in     = now > eff_refill;
      end else if (ctl.mul) begin
         prod_in = rar_pkg::PROD_W'(diff_ff) * rar_pkg::PROD_W'(rate);
      end else if (ctl.apply) begin
         if (gt_ff) begin
            refill_in = now;
         end
         if (capped == '0) begin
            deny_in  = 1'b1;
            level_in = capped;
         end else begin
            deny_in  = 1'b0;
            level_in = capped - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff  <= level_in;
      refill_ff <= refill_in;
      diff_ff   <= diff_in;
      gt_ff     <= gt_in;
      prod_ff   <= prod_in;
      deny_ff   <= deny_in;
   end

   assign level  = level_ff;
   assign refill = refill_ff;
   assign deny   = deny_ff;

endmodule

// File: hdl/replay_and_rate_admission.sv
// Top level of the replay and rate admission block: control, memories and bucket unit.
`timescale 1ns / 1ps
`include "replay_and_rate_admission_assert.svh"

// One word is taken at a time: busy rises at the edge that accepts a word and falls
// in the cycle in which rsp_strobe shows its result for exactly one cycle, and a new
// word may be started in that same cycle. An open word, or a word for a slot of PEER_SLOTS or
// above, passes only through the load and write states. An admit word passes through
// the load state, a scan of 1 to REPLAY_ENTRIES cache entries and the write state: the
// scan reads one entry per cycle through the single read port of the entry memory
// and stops at the first matching, free or expired entry. A find request that passes
// the replay check also goes through the bucket refill, the refill multiply and the
// token spend steps before the write state. Results cannot be held off by the receiver.

module replay_and_rate_admission #(
   parameter int PEER_SLOTS     = 16,
   parameter int REPLAY_ENTRIES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rar_pkg::req_type                    req_word,
   output logic                                rsp_strobe,
   output rar_pkg::rsp_type                    rsp_word,
   input  logic                                csr_write,
   input  logic [rar_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rar_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SLOT_W    = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int ENT_W     = (REPLAY_ENTRIES > 1) ? $clog2(REPLAY_ENTRIES) : 1;
   localparam int ENT_AW    = SLOT_W + ENT_W;
   localparam int ENT_DEPTH = 1 << ENT_AW;
   localparam int ENTRY_W   = 2 * rar_pkg::QID_W + rar_pkg::TIME_W;
   localparam int ROW_W     = REPLAY_ENTRIES + rar_pkg::LEVEL_W + rar_pkg::TIME_W;
   localparam logic [ENT_W-1:0] LAST_ENTRY = ENT_W'(REPLAY_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_RDIFF,
      ST_RMUL,
      ST_RAPPLY,
      ST_WRITE
   } state_type;

   state_type                       state_ff, state_in;
   rar_pkg::req_type                req_ff, req_in;
   logic                            in_range_ff, in_range_in;
   logic [REPLAY_ENTRIES-1:0]       used_ff, used_in;
   logic [ENT_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [ENT_W-1:0]                chk_idx_ff, chk_idx_in;
   logic [ENT_W-1:0]                pick_ff, pick_in;
   logic [rar_pkg::TIME_W-1:0]      pick_seen_ff, pick_seen_in;
   logic [1:0]                      verdict_ff, verdict_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rar_pkg::rsp_type                rsp_ff, rsp_in;
   logic [PEER_SLOTS-1:0]           slot_valid_ff, slot_valid_in;
   logic [rar_pkg::WINDOW_W-1:0]    window_ff;
   logic [rar_pkg::RATE_W-1:0]      rate_ff;
   logic [rar_pkg::LEVEL_W-1:0]     burst_ff;

   logic [SLOT_W-1:0]               slot_idx;
   logic                            row_ok;
   logic                            row_we;
   logic [ROW_W-1:0]                row_rd_data;
   logic [ROW_W-1:0]                row_wr_data;
   logic [REPLAY_ENTRIES-1:0]       row_used;
   logic [rar_pkg::LEVEL_W-1:0]     row_level;
   logic [rar_pkg::TIME_W-1:0]      row_refill;

   logic                            ent_we;
   logic                            ent_re;
   logic [ENT_W-1:0]                ent_rd_idx;
   logic [ENTRY_W-1:0]              ent_rd_data;
   logic [rar_pkg::QID_W-1:0]       ent_hi;
   logic [rar_pkg::QID_W-1:0]       ent_lo;
   logic [rar_pkg::TIME_W-1:0]      ent_seen;
   logic                            live;
   logic                            id_hit;
   logic [ENT_W-1:0]                scan_pick;
   state_type                       after_scan;

   rar_pkg::bucket_ctl_type         bkt_ctl;
   logic [rar_pkg::LEVEL_W-1:0]     bkt_level;
   logic [rar_pkg::TIME_W-1:0]      bkt_refill;
   logic                            bkt_deny;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;
   assign slot_idx   = SLOT_W'(req_ff.peer_slot);

   // Slot memory row: used bits of the replay entries, bucket level, refill time.
   assign row_used   = row_rd_data[ROW_W-1 -: REPLAY_ENTRIES];
   assign row_level  = row_rd_data[rar_pkg::LEVEL_W + rar_pkg::TIME_W - 1 -: rar_pkg::LEVEL_W];
   assign row_refill = row_rd_data[rar_pkg::TIME_W-1:0];
   assign row_ok     = in_range_ff & slot_valid_ff[slot_idx];
   assign row_wr_data = {used_ff, bkt_level, bkt_refill};

   rar_ram #(
      .WIDTH (ROW_W),
      .DEPTH (PEER_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (slot_idx),
      .wr_data (row_wr_data),
      .rd_en   (start & ~busy),
      .rd_addr (SLOT_W'(req_word.peer_slot)),
      .rd_data (row_rd_data)
   );

   assign ent_re     = (state_ff == ST_LOAD) || (state_ff == ST_SCAN);
   assign ent_rd_idx = (state_ff == ST_SCAN) ? rd_idx_ff : '0;

   rar_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENT_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr ({slot_idx, pick_ff}),
      .wr_data ({req_ff.query_id_high, req_ff.query_id_low, req_ff.now_s}),
      .rd_en   (ent_re),
      .rd_addr ({slot_idx, ent_rd_idx}),
      .rd_data (ent_rd_data)
   );

   assign ent_hi   = ent_rd_data[ENTRY_W-1 -: rar_pkg::QID_W];
   assign ent_lo   = ent_rd_data[rar_pkg::QID_W + rar_pkg::TIME_W - 1 -: rar_pkg::QID_W];
   assign ent_seen = ent_rd_data[rar_pkg::TIME_W-1:0];
   assign live     = used_ff[chk_idx_ff]
                     & ((req_ff.now_s - ent_seen) <= rar_pkg::TIME_W'(window_ff));
   assign id_hit   = (ent_hi == req_ff.query_id_high) && (ent_lo == req_ff.query_id_low);
   assign scan_pick  = (ent_seen < pick_seen_ff) ? chk_idx_ff : pick_ff;
   assign after_scan = req_ff.is_find ? ST_RDIFF : ST_WRITE;

   always_comb begin
      bkt_ctl       = '0;
      bkt_ctl.load  = (state_ff == ST_LOAD) && in_range_ff && (req_ff.kind == rar_pkg::KIND_ADMIT);
      bkt_ctl.fill  = (state_ff == ST_LOAD) && in_range_ff && (req_ff.kind == rar_pkg::KIND_OPEN);
      bkt_ctl.diff  = (state_ff == ST_RDIFF);
      bkt_ctl.mul   = (state_ff == ST_RMUL);
      bkt_ctl.apply = (state_ff == ST_RAPPLY);
   end

   rar_bucket u_bucket (
      .clock      (clock),
      .ctl        (bkt_ctl),
      .row_level  (row_ok ? row_level : '0),
      .row_refill (row_ok ? row_refill : '0),
      .now        (req_ff.now_s),
      .burst      (burst_ff),
      .rate       (rate_ff),
      .level      (bkt_level),
      .refill     (bkt_refill),
      .deny       (bkt_deny)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      in_range_in   = in_range_ff;
      used_in       = used_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      pick_in       = pick_ff;
      pick_seen_in  = pick_seen_ff;
      verdict_in    = verdict_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      slot_valid_in = slot_valid_ff;
      row_we        = 1'b0;
      ent_we        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_word;
               in_range_in = 32'(req_word.peer_slot) < 32'(PEER_SLOTS);
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            verdict_in   = rar_pkg::VERDICT_ACCEPT;
            rd_idx_in    = ENT_W'(1);
            chk_idx_in   = '0;
            pick_in      = '0;
            pick_seen_in = '1;
            if (!in_range_ff || (req_ff.kind == rar_pkg::KIND_OPEN)) begin
               used_in  = '0;
               state_in = ST_WRITE;
            end else begin
               used_in  = row_ok ? row_used : '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (live && id_hit) begin
               verdict_in = rar_pkg::VERDICT_REPLAY;
               state_in   = ST_WRITE;
            end else if (!live) begin
               pick_in             = chk_idx_ff;
               used_in[chk_idx_ff] = 1'b1;
               state_in            = after_scan;
            end else begin
               pick_in = scan_pick;
               if (ent_seen < pick_seen_ff) begin
                  pick_seen_in = ent_seen;
               end
               if (chk_idx_ff == LAST_ENTRY) begin
                  used_in[scan_pick] = 1'b1;
                  state_in           = after_scan;
               end else begin
                  chk_idx_in = chk_idx_ff + 1'b1;
               end
            end
         end
         ST_RDIFF: begin
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            state_in = ST_RAPPLY;
         end
         ST_RAPPLY: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            rsp_valid_in = 1'b1;
            if (!in_range_ff) begin
               rsp_in.verdict     = (req_ff.kind == rar_pkg::KIND_OPEN) ?
                                    rar_pkg::VERDICT_ACCEPT : rar_pkg::VERDICT_RATE;
               rsp_in.tokens_left = '0;
            end else begin
               rsp_in.verdict     = bkt_deny ? rar_pkg::VERDICT_RATE : verdict_ff;
               rsp_in.tokens_left = bkt_level;
               if (verdict_ff != rar_pkg::VERDICT_REPLAY) begin
                  row_we                  = 1'b1;
                  slot_valid_in[slot_idx] = 1'b1;
                  ent_we                  = (req_ff.kind == rar_pkg::KIND_ADMIT);
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
         slot_valid_ff <= '0;
         window_ff     <= rar_pkg::WINDOW_W'(300);
         rate_ff       <= rar_pkg::RATE_W'(1);
         burst_ff      <= rar_pkg::LEVEL_W'(8);
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
         slot_valid_ff <= slot_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               rar_pkg::CSR_WINDOW: window_ff <= csr_data[rar_pkg::WINDOW_W-1:0];
               rar_pkg::CSR_RATE:   rate_ff   <= csr_data[rar_pkg::RATE_W-1:0];
               rar_pkg::CSR_BURST:  burst_ff  <= csr_data[rar_pkg::LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      in_range_ff  <= in_range_in;
      used_ff      <= used_in;
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      pick_ff      <= pick_in;
      pick_seen_ff <= pick_seen_in;
      verdict_ff   <= verdict_in;
   end

   `RAR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted word did not raise busy.")
   `RAR_ASSERT_IMPLY(a_rsp_idle, rsp_strobe, !busy, "Result shown while a word is in work.")
   `RAR_ASSERT_NEXT(a_rsp_single, rsp_strobe, !rsp_strobe, "Result strobe held for two cycles.")
   `RAR_ASSERT_IMPLY(a_bkt_ctl, 1'b1, $onehot0(bkt_ctl), "Bucket unit got two steps at once.")

endmodule
